@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is released.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ rtl/itoa_pkg.sv @@
// Shared types, constants and the digit-to-character function.
package itoa_pkg;

    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int IN_VALUE_W         = 64;
    localparam int NUM_DIGITS         = 20;
    localparam int DIGIT_IDX_W        = 5;
    localparam int DIGIT_BITS         = NUM_DIGITS * 4;
    localparam int CHAR_W             = 7;

    localparam logic RADIX_HEX = 1'b0;
    localparam logic RADIX_DEC = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_F    = 7'd102;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digit_vec;

    typedef struct packed {
        t_digit_vec              digits;
        logic [DIGIT_IDX_W-1:0]  msd;
    } t_conv_result;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

@@ rtl/itoa_front.sv @@
// Input queue: accepts words, masks the value and holds up to two jobs.
module itoa_front
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_req_type,
    input  logic [IN_VALUE_W-1:0] i_value,
    output logic                  o_job_valid,
    input  logic                  i_job_take,
    output logic                  o_job_dec,
    output logic [VALUE_BITS-1:0] o_job_value
);

    logic                  r_type [2];
    logic [VALUE_BITS-1:0] r_val  [2];
    logic                  r_head, n_head;
    logic [1:0]            r_count, n_count;
    logic                  wr_en, rd_en, tail;

    assign o_full      = (r_count == 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_job_take && o_job_valid;
    assign tail        = r_head ^ r_count[0];
    assign o_job_dec   = r_type[r_head];
    assign o_job_value = r_val[r_head];

    always_comb begin
        n_head  = rd_en ? ~r_head : r_head;
        n_count = r_count + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Bits above VALUE_BITS are dropped here.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_type[tail] <= i_req_type;
            r_val[tail]  <= i_value[VALUE_BITS-1:0];
        end
    end

endmodule

@@ rtl/itoa_conv.sv @@
// Converter: hex nibbles load at once, decimal runs shift-add-3 four bits a cycle.
module itoa_conv
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_take,
    input  logic                  i_job_dec,
    input  logic [VALUE_BITS-1:0] i_job_value,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_conv_result          o_res
);

    localparam int STEPS    = (VALUE_BITS + 3) / 4;
    localparam int PAD_BITS = STEPS * 4;
    localparam int STEP_W   = $clog2(STEPS);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_step, n_step;
    t_digit_vec          r_bcd, n_bcd;
    logic [PAD_BITS-1:0] r_bin, n_bin;

    logic [PAD_BITS-1:0] padded;
    t_digit_vec          dab_bcd;
    logic [PAD_BITS-1:0] dab_bin;
    logic                res_take;
    logic [DIGIT_IDX_W-1:0] msd;

    assign padded     = PAD_BITS'(i_job_value);
    assign res_take   = r_done && i_res_ready;
    assign o_job_take = i_job_valid && !r_busy && (!r_done || i_res_ready);

    // Four shift-add-3 steps per cycle.
    always_comb begin
        dab_bcd = r_bcd;
        dab_bin = r_bin;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (dab_bcd[d] >= 4'd5) begin
                    dab_bcd[d] = dab_bcd[d] + 4'd3;
                end
            end
            dab_bcd = t_digit_vec'({dab_bcd[NUM_DIGITS-1:0], dab_bin[PAD_BITS-1]});
            dab_bin = {dab_bin[PAD_BITS-2:0], 1'b0};
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_step = r_step;
        n_bcd  = r_bcd;
        n_bin  = r_bin;
        if (o_job_take) begin
            if (i_job_dec == RADIX_DEC) begin
                n_busy = 1'b1;
                n_done = 1'b0;
                n_step = '0;
                n_bcd  = '0;
                n_bin  = padded;
            end else begin
                n_done = 1'b1;
                n_bcd  = t_digit_vec'(DIGIT_BITS'(padded));
            end
        end else if (res_take) begin
            n_done = 1'b0;
        end
        if (r_busy) begin
            n_bcd  = dab_bcd;
            n_bin  = dab_bin;
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    // Highest nonzero digit; zero keeps index 0 so it prints one '0'.
    always_comb begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                msd = DIGIT_IDX_W'(i);
            end
        end
    end

    assign o_res_valid   = r_done;
    assign o_res.digits  = r_bcd;
    assign o_res.msd     = msd;

endmodule

@@ rtl/itoa_emit.sv @@
// Emitter: holds one converted number and pops its characters out, top digit first.
module itoa_emit
    import itoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    output logic              o_res_ready,
    input  t_conv_result      i_res,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last_char
);

    logic                   r_busy, n_busy;
    logic [DIGIT_IDX_W-1:0] r_ptr, n_ptr;
    t_digit_vec             r_dig, n_dig;
    logic                   at_last, load;

    assign at_last     = (r_ptr == '0);
    assign o_res_ready = !r_busy || (i_pop && at_last);
    assign load        = i_res_valid && o_res_ready;
    assign o_empty     = !r_busy;
    assign o_char_code = digit_char(r_dig[r_ptr]);
    assign o_last_char = at_last;

    always_comb begin
        n_busy = r_busy;
        n_ptr  = r_ptr;
        n_dig  = r_dig;
        if (load) begin
            n_busy = 1'b1;
            n_ptr  = i_res.msd;
            n_dig  = i_res.digits;
        end else if (i_pop && r_busy) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else begin
                n_ptr = r_ptr - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ptr  <= '0;
        end else begin
            r_busy <= n_busy;
            r_ptr  <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
    end

endmodule

@@ rtl/integer_to_ascii_digits.sv @@
// Top level: unsigned integer to ASCII digit characters.
//
// Input queue: a word {i_req_type, i_value} enters at a clock edge with i_push high
// and o_full low. i_req_type 0 selects lowercase hex, 1 decimal; only the low
// VALUE_BITS bits of i_value are converted.
// Output queue: while o_empty is low, o_char_code/o_last_char show the oldest
// character; it is taken at an edge with i_pop high. Digits come most significant
// first, leading zeros dropped, zero as a single '0'; o_last_char marks the final one.
// Path: a pushed word is registered in the input queue, then in the converter result
// register (decimal after the shift-add-3 loop, four bits a cycle), then the emitter.
// Throughput: hex characters leave at one per cycle while the receiver pops; a decimal
// number keeps the converter loop busy, and no new number is taken until it is done.
// A two-entry input queue and the converter result register let the next number be
// taken and converted while the current one is still being popped.
// Reset (synchronous, active low) drops all queued numbers: o_empty high, o_full low.
// A stalled receiver holds the shown character; the queues fill and o_full rises.
module integer_to_ascii_digits
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_req_type,
    input  logic [IN_VALUE_W-1:0] i_value,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [CHAR_W-1:0]     o_char_code,
    output logic                  o_last_char
);

    logic                  job_valid, job_take, job_dec;
    logic [VALUE_BITS-1:0] job_value;
    logic                  res_valid, res_ready;
    t_conv_result          res;

    itoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .o_job_valid (job_valid),
        .i_job_take  (job_take),
        .o_job_dec   (job_dec),
        .o_job_value (job_value)
    );

    itoa_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_take  (job_take),
        .i_job_dec   (job_dec),
        .i_job_value (job_value),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    itoa_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

@@ rtl/itoa_checker.sv @@
// Port-level checks for the converter top level, bound to it.
`include "assert_macros.svh"

module itoa_checker
    import itoa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_full,
    input logic              o_empty,
    input logic              i_pop,
    input logic [CHAR_W-1:0] o_char_code,
    input logic              o_last_char
);

    logic              char_ok;
    logic              more_pop;
    logic              stalled;
    logic              lead_zero;
    logic              r_gap;
    logic [CHAR_W+1:0] shown;

    assign char_ok   = (o_char_code >= CHAR_ZERO && o_char_code <= CHAR_NINE) ||
                       (o_char_code >= CHAR_A && o_char_code <= CHAR_F);
    assign more_pop  = !o_empty && i_pop && !o_last_char;
    assign stalled   = !o_empty && !i_pop;
    assign lead_zero = r_gap && !o_empty && !o_last_char && (o_char_code == CHAR_ZERO);
    assign shown     = {o_empty, o_char_code, o_last_char};

    // Mark that the next shown word opens a new number.
    always_ff @(posedge i_clk) begin
        r_gap <= o_empty || (i_pop && o_last_char);
    end

    // Reset drops every queued number.
    `ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> o_empty && !o_full, "not clear after reset")

    // Only digit characters leave the block.
    `ASSERT_CLK_RST(a_char_legal, i_clk, i_rst_n, !o_empty |-> char_ok, "illegal character code")

    // A number never breaks off before its last character.
    `ASSERT_CLK_RST(a_number_continues, i_clk, i_rst_n, more_pop |=> !o_empty, "number cut short")

    // The leading digit of a multi-digit number is never zero.
    `ASSERT_CLK_RST(a_no_lead_zero, i_clk, i_rst_n, !lead_zero, "leading zero emitted")

    // A stalled character holds.
    `ASSERT_CLK_RST(a_stall_hold, i_clk, i_rst_n, stalled |=> $stable(shown), "stall not held")

endmodule

bind integer_to_ascii_digits itoa_checker u_checker (.*);

@@ sim/testbench.sv @@
// Testbench for integer_to_ascii_digits: directed table plus random numbers, scoreboarded.
module testbench;
    import itoa_pkg::*;

    localparam int VALUE_BITS  = DEFAULT_VALUE_BITS;
    localparam int RAND_ITEMS  = 350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = VALUE_BITS / 4 + 30;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_word;

    typedef struct {
        logic                  radix;
        logic [IN_VALUE_W-1:0] num;
        string                 text;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    logic                  o_full;
    logic                  i_req_type;
    logic [IN_VALUE_W-1:0] i_value;
    logic                  o_empty;
    logic                  i_pop;
    logic [CHAR_W-1:0]     o_char_code;
    logic                  o_last_char;

    t_char_word  pending_chars[$];
    t_row        directed_rows[20];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    integer_to_ascii_digits #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch @%0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Expected characters of one number, most significant first.
    function automatic void queue_digits(input logic radix, input logic [IN_VALUE_W-1:0] num);
        string                 glyphs;
        logic [63:0]           v;
        logic [3:0]            digits[NUM_DIGITS];
        int                    count;
        t_char_word            w;
        byte                   glyph;
        glyphs = "0123456789abcdef";
        v      = (VALUE_BITS >= 64) ? num : (num & ((64'd1 << VALUE_BITS) - 64'd1));
        count  = 0;
        do begin
            if (radix == RADIX_DEC) begin
                digits[count] = 4'(v % 64'd10);
                v             = v / 64'd10;
            end else begin
                digits[count] = v[3:0];
                v             = v >> 4;
            end
            count++;
        end while (v != 64'd0 && count < NUM_DIGITS);
        for (int k = count - 1; k >= 0; k--) begin
            glyph  = glyphs[digits[k]];
            w.code = glyph[CHAR_W-1:0];
            w.last = (k == 0);
            pending_chars.push_back(w);
        end
    endfunction

    // Expectation spelled out by hand in the table.
    function automatic void queue_text(input string text);
        t_char_word w;
        byte        glyph;
        for (int k = 0; k < text.len(); k++) begin
            glyph  = text[k];
            w.code = glyph[CHAR_W-1:0];
            w.last = (k == text.len() - 1);
            pending_chars.push_back(w);
        end
    endfunction

    // Mix of magnitudes and decimal/hex digit-count boundaries.
    function automatic logic [IN_VALUE_W-1:0] pick_value();
        logic [63:0] v;
        int          k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = v >> $urandom_range(0, 63);
            5, 6: begin
                k = $urandom_range(0, 19);
                v = 64'd1;
                for (int i = 0; i < k; i++) begin
                    v = v * 64'd10;
                end
                if ($urandom_range(0, 1) == 1) begin
                    v = v - 64'd1;
                end
            end
            7: begin
                v = 64'd1 << (4 * $urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1) begin
                    v = v - 64'd1;
                end
            end
            8: v = 64'($urandom_range(0, 20));
            default: ;
        endcase
        return v;
    endfunction

    // Called at a falling edge; returns at a falling edge with push low.
    task automatic send_number(input logic radix, input logic [IN_VALUE_W-1:0] num,
                               input string text);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_push     = 1'b1;
        i_req_type = radix;
        i_value    = num;
        do @(posedge i_clk); while (o_full);
        if (text.len() != 0) begin
            queue_text(text);
        end else begin
            queue_digits(radix, num);
        end
        @(negedge i_clk);
        i_push = 1'b0;
    endtask

    task automatic wait_drained();
        i_push = 1'b0;
        while (pending_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Receiver: decide pop at each falling edge.
    initial begin
        i_pop = 1'b0;
        forever begin
            @(negedge i_clk);
            i_pop = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word code=%0d last=%0b",
                                          o_char_code, o_last_char));
            end else begin
                if (o_char_code !== pending_chars[0].code) begin
                    report_mismatch($sformatf("char_code got %0d want %0d",
                                              o_char_code, pending_chars[0].code));
                end
                if (o_last_char !== pending_chars[0].last) begin
                    report_mismatch($sformatf("last_char got %0b want %0b",
                                              o_last_char, pending_chars[0].last));
                end
                void'(pending_chars.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        cycle_count   = 0;
        error_count   = 0;
        send_idle_pct = 29;
        recv_idle_pct = 60;
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_req_type    = RADIX_HEX;
        i_value       = '0;

        directed_rows = '{
            '{RADIX_HEX, 64'd0,                  "0"},
            '{RADIX_DEC, 64'd0,                  "0"},
            '{RADIX_HEX, 64'hffff_ffff_ffff_ffff, "ffffffffffffffff"},
            '{RADIX_DEC, 64'hffff_ffff_ffff_ffff, "18446744073709551615"},
            '{RADIX_HEX, 64'd1,                  "1"},
            '{RADIX_DEC, 64'd1,                  "1"},
            '{RADIX_DEC, 64'd9,                  "9"},
            '{RADIX_DEC, 64'd10,                 "10"},
            '{RADIX_HEX, 64'hf,                  "f"},
            '{RADIX_HEX, 64'h10,                 "10"},
            '{RADIX_HEX, 64'ha,                  "a"},
            '{RADIX_HEX, 64'h0123_4567_89ab_cdef, ""},
            '{RADIX_HEX, 64'hfedc_ba98_7654_3210, ""},
            '{RADIX_DEC, 64'd10000000000000000000, "10000000000000000000"},
            '{RADIX_DEC, 64'd9999999999999999999,  ""},
            '{RADIX_HEX, 64'h8000_0000_0000_0000, "8000000000000000"},
            '{RADIX_DEC, 64'h8000_0000_0000_0000, ""},
            '{RADIX_DEC, 64'd12345678901234567890, ""},
            '{RADIX_HEX, 64'h5555_aaaa_5555_aaaa, ""},
            '{RADIX_DEC, 64'h0000_0000_ffff_ffff, ""}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            send_number(directed_rows[r].radix, directed_rows[r].num, directed_rows[r].text);
        end

        for (int phase = 0; phase < 3; phase++) begin
            // Hold off the sender until the output side has caught up.
            wait_drained();
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_ITEMS / 3; n++) begin
                send_number(1'($urandom_range(0, 1)), pick_value(), "");
            end
        end

        wait_drained();
        recv_idle_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
